### hdl/mcg_pkg.sv
// shared types, constants and tables for the month calendar grid
package mcg_pkg;

  localparam int ROWS = 6;
  localparam int COLS = 7;
  localparam logic [2:0] LAST_ROW = 3'(ROWS - 1);
  localparam logic [13:0] FIRST_YEAR = 14'd1753;
  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_MAR = 4'd3;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  // reciprocal constants for division by 25 and by 7
  localparam logic [11:0] RECIP_25 = 12'd2622;
  localparam int SHIFT_25 = 16;
  localparam logic [15:0] RECIP_7 = 16'd37450;
  localparam int SHIFT_7 = 18;

  typedef struct packed {
    logic       bad;
    logic [2:0] first;
    logic [4:0] len;
  } mcg_item_t;

  function automatic logic [2:0] month_offset(input logic [3:0] m);
    logic [2:0] r;
    case (m)
      4'd1:    r = 3'd0;
      4'd2:    r = 3'd3;
      4'd3:    r = 3'd2;
      4'd4:    r = 3'd5;
      4'd5:    r = 3'd0;
      4'd6:    r = 3'd3;
      4'd7:    r = 3'd5;
      4'd8:    r = 3'd1;
      4'd9:    r = 3'd4;
      4'd10:   r = 3'd6;
      4'd11:   r = 3'd2;
      4'd12:   r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    case (m)
      4'd2:    r = leap ? 5'd29 : 5'd28;
      4'd4:    r = 5'd30;
      4'd6:    r = 5'd30;
      4'd9:    r = 5'd30;
      4'd11:   r = 5'd30;
      default: r = 5'd31;
    endcase
    return r;
  endfunction

  // x / 25 for x below 4096
  function automatic logic [7:0] div25(input logic [11:0] x);
    logic [23:0] p;
    p = x * RECIP_25;
    return 8'(p >> SHIFT_25);
  endfunction

endpackage

### hdl/mcg_front.sv
// front pipeline: request intake, range check, weekday and month length
module mcg_front #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [3:0]        month,
  input  logic [13:0]       year,
  input  logic              credit,
  output logic              full,
  output logic              item_valid,
  output mcg_pkg::mcg_item_t item
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] occ;
  logic          accept;

  logic          bad_in;
  logic [13:0]   yy;
  logic [11:0]   y4;
  logic [9:0]    y16;
  logic [7:0]    p100;
  logic [7:0]    p400;
  logic          leap_in;

  logic          s1_valid;
  logic          s1_bad;
  logic [3:0]    s1_month;
  logic [13:0]   s1_yy;
  logic [11:0]   s1_q4;
  logic [7:0]    s1_q100;
  logic [5:0]    s1_q400;
  logic          s1_leap;

  logic [14:0]   sum;
  logic [30:0]   prod7;

  logic          s2_valid;
  logic          s2_bad;
  logic [3:0]    s2_month;
  logic          s2_leap;
  logic [14:0]   s2_sum;
  logic [11:0]   s2_q7;

  logic [14:0]   rem7;

  assign full   = (occ == CW'(DEPTH));
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ + CW'(accept) - CW'(credit);
    end
  end

  // stage 1: range check, year quotients and leap rule
  always_comb begin
    bad_in  = (month < mcg_pkg::MONTH_JAN) || (month > mcg_pkg::MONTH_DEC) ||
              (year < mcg_pkg::FIRST_YEAR);
    yy      = (month < mcg_pkg::MONTH_MAR) ? year - 14'd1 : year;
    y4      = year[13:2];
    y16     = year[13:4];
    p100    = mcg_pkg::div25(y4);
    p400    = mcg_pkg::div25({2'b00, y16});
    leap_in = ((year[1:0] == 2'b00) && (12'(p100 * 8'd25) != y4)) ||
              ((year[3:0] == 4'b0000) && (10'(p400 * 8'd25) == y16));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_bad   <= bad_in;
    s1_month <= month;
    s1_yy    <= yy;
    s1_q4    <= yy[13:2];
    s1_q100  <= mcg_pkg::div25(yy[13:2]);
    s1_q400  <= 6'(mcg_pkg::div25({2'b00, yy[13:4]}));
    s1_leap  <= leap_in;
  end

  // stage 2: day count sum and quotient by seven
  always_comb begin
    sum   = 15'(s1_yy) + 15'(s1_q4) - 15'(s1_q100) + 15'(s1_q400) +
            15'(mcg_pkg::month_offset(s1_month)) + 15'd1;
    prod7 = sum * mcg_pkg::RECIP_7;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_bad   <= s1_bad;
    s2_month <= s1_month;
    s2_leap  <= s1_leap;
    s2_sum   <= sum;
    s2_q7    <= 12'(prod7 >> mcg_pkg::SHIFT_7);
  end

  // stage 3: weekday of the first and month length
  assign rem7 = s2_sum - ({3'b000, s2_q7} * 15'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    item.bad   <= s2_bad;
    item.first <= rem7[2:0];
    item.len   <= mcg_pkg::month_days(s2_month, s2_leap);
  end

endmodule

### hdl/mcg_queue.sv
// short queue between the front pipeline and the row generator
module mcg_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  mcg_pkg::mcg_item_t wr_item,
  input  logic              rd,
  output logic              rd_valid,
  output mcg_pkg::mcg_item_t rd_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mcg_pkg::mcg_item_t slots [DEPTH];
  logic [AW-1:0]      wptr;
  logic [AW-1:0]      rptr;
  logic [CW-1:0]      count;

  assign rd_valid = (count != '0);
  assign rd_item  = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (rd) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      count <= count + CW'(wr) - CW'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= wr_item;
    end
  end

endmodule

### hdl/mcg_back.sv
// row generator: expands one month into week rows into the output register
module mcg_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  mcg_pkg::mcg_item_t q_item,
  output logic              q_pop,
  input  logic              pop,
  output logic              empty,
  output logic [2:0]        week_row,
  output logic [4:0]        day_sun,
  output logic [4:0]        day_mon,
  output logic [4:0]        day_tue,
  output logic [4:0]        day_wed,
  output logic [4:0]        day_thu,
  output logic [4:0]        day_fri,
  output logic [4:0]        day_sat,
  output logic              last_row,
  output logic              bad_input
);

  logic               out_valid;
  logic               cur_active;
  mcg_pkg::mcg_item_t cur;
  logic [2:0]         row;

  logic               load_ok;
  logic               src_valid;
  mcg_pkg::mcg_item_t src;
  logic [2:0]         src_row;
  logic               src_end;
  logic [5:0]         pos;
  logic [5:0]         off;
  logic [4:0]         cells [mcg_pkg::COLS];
  logic [4:0]         days  [mcg_pkg::COLS];

  assign empty     = !out_valid;
  assign load_ok   = !out_valid || pop;
  assign src_valid = cur_active || q_valid;
  assign src       = cur_active ? cur : q_item;
  assign src_row   = cur_active ? row : 3'd0;
  assign src_end   = src.bad || (src_row == mcg_pkg::LAST_ROW);
  assign q_pop     = load_ok && !cur_active && q_valid;

  always_comb begin
    for (int c = 0; c < mcg_pkg::COLS; c++) begin
      pos      = 6'(src_row * 3'd7) + 6'(c);
      off      = pos - 6'(src.first);
      cells[c] = 5'd0;
      if (!src.bad && (pos >= 6'(src.first)) && (off < 6'(src.len))) begin
        cells[c] = 5'(off + 6'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      cur_active <= 1'b0;
    end else if (load_ok) begin
      out_valid  <= src_valid;
      cur_active <= src_valid && !src_end;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && src_valid) begin
      cur       <= src;
      row       <= src_row + 3'd1;
      week_row  <= src_row;
      last_row  <= src_end;
      bad_input <= src.bad;
      days      <= cells;
    end
  end

  assign day_sun = days[0];
  assign day_mon = days[1];
  assign day_tue = days[2];
  assign day_wed = days[3];
  assign day_thu = days[4];
  assign day_fri = days[5];
  assign day_sat = days[6];

endmodule

### hdl/month_calendar_grid.sv
// top level of the month calendar grid generator
//
//   channel   handshake      payload
//   request   push / full    month, year
//   result    pop / empty    week_row, day_sun..day_sat, last_row, bad_input
//
// a valid month gives six rows, one per cycle while pop is held; a bad request gives one row
// a new request enters the single result register only after the last row of the one before
// after a request is taken, its first row passes two more front stages, the queue
// and the output register
// rst is synchronous and clears all valid state; no clearing pass
// full rises once QUEUE_DEPTH requests sit in the front pipeline and the queue
// a stalled result side holds the row and lets the front keep taking requests until full
module month_calendar_grid #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [3:0]  month,
  input  logic [13:0] year,
  input  logic        pop,
  output logic        empty,
  output logic [2:0]  week_row,
  output logic [4:0]  day_sun,
  output logic [4:0]  day_mon,
  output logic [4:0]  day_tue,
  output logic [4:0]  day_wed,
  output logic [4:0]  day_thu,
  output logic [4:0]  day_fri,
  output logic [4:0]  day_sat,
  output logic        last_row,
  output logic        bad_input
);

  logic               item_valid;
  mcg_pkg::mcg_item_t item;
  logic               q_valid;
  mcg_pkg::mcg_item_t q_item;
  logic               q_pop;

  mcg_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .month      (month),
    .year       (year),
    .credit     (q_pop),
    .full       (full),
    .item_valid (item_valid),
    .item       (item)
  );

  mcg_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (item_valid),
    .wr_item  (item),
    .rd       (q_pop),
    .rd_valid (q_valid),
    .rd_item  (q_item)
  );

  mcg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .pop       (pop),
    .empty     (empty),
    .week_row  (week_row),
    .day_sun   (day_sun),
    .day_mon   (day_mon),
    .day_tue   (day_tue),
    .day_wed   (day_wed),
    .day_thu   (day_thu),
    .day_fri   (day_fri),
    .day_sat   (day_sat),
    .last_row  (last_row),
    .bad_input (bad_input)
  );

endmodule
